FILE: hdl/delimited_frame_receiver_sum_check_assert.svh
// Assertion macros shared by the checker of the frame receiver.
// Depends on nothing; included by the checker file only.
`ifndef DELIMITED_FRAME_RECEIVER_SUM_CHECK_ASSERT_SVH
`define DELIMITED_FRAME_RECEIVER_SUM_CHECK_ASSERT_SVH

// Same-cycle implication, disabled while dis is high.
`define DFRSC_ASSERT_NOW(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error("frame receiver check failed");

// Next-cycle implication, disabled while dis is high.
`define DFRSC_ASSERT_NEXT(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error("frame receiver check failed");

`endif

FILE: hdl/dfrsc_pkg.sv
// Package of the delimited frame receiver: beat types, codes and constants.
// Depends on nothing; used by the top level and by its checker.
`timescale 1ns / 1ps
`default_nettype none

package dfrsc_pkg;

   // Frame storage bound; the programmed limit is capped at this value.
   localparam int unsigned COUNT_W   = 9;
   localparam logic [COUNT_W-1:0] MAX_FRAME = 9'd256;

   // Value the running sum must hold when the end character arrives.
   localparam logic [7:0] SUM_GOOD = 8'hFF;

   // Input event codes.
   localparam logic [1:0] MODE_BYTE    = 2'd0;
   localparam logic [1:0] MODE_TIMEOUT = 2'd1;
   localparam logic [1:0] MODE_FAULT   = 2'd2;

   // Result status codes.
   localparam logic [2:0] ST_IN_FRAME = 3'd0;
   localparam logic [2:0] ST_OK       = 3'd1;
   localparam logic [2:0] ST_TOO_LONG = 3'd2;
   localparam logic [2:0] ST_TIMEOUT  = 3'd3;
   localparam logic [2:0] ST_FAULT    = 3'd4;

   // Configuration register indexes.
   localparam logic [1:0] CSR_START_CHAR = 2'd0;
   localparam logic [1:0] CSR_END_CHAR   = 2'd1;
   localparam logic [1:0] CSR_MAX_LEN    = 2'd2;

   // Configuration reset values.
   localparam logic [7:0]         START_CHAR_RST = 8'd16;
   localparam logic [7:0]         END_CHAR_RST   = 8'd22;
   localparam logic [COUNT_W-1:0] MAX_LEN_RST    = 9'd256;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] rx_byte;
   } req_data_type;

   typedef struct packed {
      logic [7:0]         byte_out;
      logic [COUNT_W-1:0] position;
      logic [2:0]         status;
      logic               last;
   } rsp_data_type;

endpackage

`default_nettype wire

FILE: hdl/delimited_frame_receiver_sum_check.sv
// Delimited frame receiver with an 8-bit additive checksum.
// A result beat is registered; it passes through the skid register while rsp is stalled.
// Throughput: one request beat per cycle unless the skid register is full; a two-entry
// output buffer (result plus skid register) lets a beat enter while a result waits on rsp.
// Reset (synchronous, active high): hunting state, sum and count cleared, registers at their
// default characters and limit, output buffer empty.
`timescale 1ns / 1ps
`default_nettype none

module delimited_frame_receiver_sum_check (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // Request channel: received bytes, timeouts and link faults.
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire dfrsc_pkg::req_data_type req_data,
   // Result channel.
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output dfrsc_pkg::rsp_data_type      rsp_data,
   // Configuration write port.
   input  wire logic                    csr_wr_en,
   input  wire logic [1:0]              csr_index,
   input  wire logic [dfrsc_pkg::COUNT_W-1:0] csr_wdata
);

   // Configuration registers.
   logic [7:0]                    start_char_ff;
   logic [7:0]                    end_char_ff;
   logic [dfrsc_pkg::COUNT_W-1:0] max_len_ff;

   // Frame state.
   logic                          in_frame_ff, in_frame_in;
   logic [7:0]                    running_sum_ff, running_sum_in;
   logic [dfrsc_pkg::COUNT_W-1:0] byte_count_ff, byte_count_in;

   // Output buffer: the result register feeds rsp, the skid register catches a result
   // that arrives while the result register is held by a stall.
   logic                          out_valid_ff, out_valid_in;
   dfrsc_pkg::rsp_data_type       out_data_ff, out_data_in;
   logic                          skid_valid_ff, skid_valid_in;
   dfrsc_pkg::rsp_data_type       skid_data_ff, skid_data_in;

   logic                          accept;
   logic                          out_take;
   logic                          res_valid;
   dfrsc_pkg::rsp_data_type       res;
   logic [dfrsc_pkg::COUNT_W-1:0] limit;
   logic [dfrsc_pkg::COUNT_W-1:0] count_next;

   // The request side is held off only while the skid register is occupied, so a beat may
   // still enter while one finished result sits in the result register.
   assign req_stall = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign accept   = req_valid && !skid_valid_ff;
   assign out_take = out_valid_ff && !rsp_stall;

   // The programmed limit is capped at the frame storage bound. Small values such as
   // zero or one simply make the second byte of a frame too long.
   assign limit      = (max_len_ff < dfrsc_pkg::MAX_FRAME) ? max_len_ff : dfrsc_pkg::MAX_FRAME;
   assign count_next = byte_count_ff + 9'd1;

   // Configuration writes. An index beyond the register list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_char_ff <= dfrsc_pkg::START_CHAR_RST;
         end_char_ff   <= dfrsc_pkg::END_CHAR_RST;
         max_len_ff    <= dfrsc_pkg::MAX_LEN_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            dfrsc_pkg::CSR_START_CHAR: start_char_ff <= csr_wdata[7:0];
            dfrsc_pkg::CSR_END_CHAR:   end_char_ff   <= csr_wdata[7:0];
            dfrsc_pkg::CSR_MAX_LEN:    max_len_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Frame logic: one compare-and-add per accepted beat.
   always_comb begin
      in_frame_in    = in_frame_ff;
      running_sum_in = running_sum_ff;
      byte_count_in  = byte_count_ff;
      res_valid      = 1'b0;
      res            = '0;

      if (accept) begin
         case (req_data.mode)
            dfrsc_pkg::MODE_TIMEOUT,
            dfrsc_pkg::MODE_FAULT: begin
               // A timeout or fault always reports, even while hunting, and abandons
               // any frame in progress.
               res_valid      = 1'b1;
               res.byte_out   = 8'd0;
               res.position   = in_frame_ff ? byte_count_ff : '0;
               res.status     = (req_data.mode == dfrsc_pkg::MODE_TIMEOUT) ?
                                dfrsc_pkg::ST_TIMEOUT : dfrsc_pkg::ST_FAULT;
               res.last       = 1'b1;
               in_frame_in    = 1'b0;
               running_sum_in = 8'd0;
               byte_count_in  = '0;
            end
            dfrsc_pkg::MODE_BYTE: begin
               if (!in_frame_ff) begin
                  // Hunting: everything but the start character is dropped silently.
                  if (req_data.rx_byte == start_char_ff) begin
                     res_valid      = 1'b1;
                     res.byte_out   = req_data.rx_byte;
                     res.position   = 9'd1;
                     res.status     = dfrsc_pkg::ST_IN_FRAME;
                     res.last       = 1'b0;
                     in_frame_in    = 1'b1;
                     running_sum_in = 8'd0;
                     byte_count_in  = 9'd1;
                  end
               end else begin
                  res_valid    = 1'b1;
                  res.byte_out = req_data.rx_byte;
                  res.position = count_next;
                  if (count_next >= limit) begin
                     // The length check wins over a matching end character.
                     res.status     = dfrsc_pkg::ST_TOO_LONG;
                     res.last       = 1'b1;
                     in_frame_in    = 1'b0;
                     running_sum_in = 8'd0;
                     byte_count_in  = '0;
                  end else if (req_data.rx_byte == end_char_ff &&
                               running_sum_ff == dfrsc_pkg::SUM_GOOD) begin
                     // The closing byte is not added to the sum.
                     res.status     = dfrsc_pkg::ST_OK;
                     res.last       = 1'b1;
                     in_frame_in    = 1'b0;
                     running_sum_in = 8'd0;
                     byte_count_in  = '0;
                  end else begin
                     res.status     = dfrsc_pkg::ST_IN_FRAME;
                     res.last       = 1'b0;
                     running_sum_in = running_sum_ff + req_data.rx_byte;
                     byte_count_in  = count_next;
                  end
               end
            end
            default: begin
               // The unused event code is ignored: no result and no state change.
            end
         endcase
      end
   end

   // Output buffer steering. While the skid register is full no beat is accepted, so it
   // only drains into the result register. Otherwise a new result goes to the result
   // register when that is free or being taken, and to the skid register when it is held.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;

      if (skid_valid_ff) begin
         if (out_take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         if (!out_valid_ff || out_take) begin
            out_valid_in = 1'b1;
            out_data_in  = res;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = res;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff    <= 1'b0;
         running_sum_ff <= 8'd0;
         byte_count_ff  <= '0;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         in_frame_ff    <= in_frame_in;
         running_sum_ff <= running_sum_in;
         byte_count_ff  <= byte_count_in;
         out_valid_ff   <= out_valid_in;
         skid_valid_ff  <= skid_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

`default_nettype wire

FILE: hdl/dfrsc_checker.sv
// Port-level checker for the delimited frame receiver, bound to its top level.
// Depends on dfrsc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "delimited_frame_receiver_sum_check_assert.svh"

module dfrsc_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire dfrsc_pkg::req_data_type       req_data,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire dfrsc_pkg::rsp_data_type       rsp_data
);

   logic req_take;

   assign req_take = req_valid && !req_stall;

   // A held result keeps its valid and payload.
   `DFRSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data))

   // Reset leaves the output buffer empty.
   `DFRSC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // With nothing waiting on rsp the buffer has room, so requests are never held off.
   `DFRSC_ASSERT_NOW(a_empty_no_stall, clock, reset, !rsp_valid, !req_stall)

   // A timeout taken while the output is empty is reported in the very next cycle.
   `DFRSC_ASSERT_NEXT(a_timeout_report, clock, reset,
      req_take && req_data.mode == dfrsc_pkg::MODE_TIMEOUT && !rsp_valid,
      rsp_valid && rsp_data.status == dfrsc_pkg::ST_TIMEOUT && rsp_data.last &&
      rsp_data.byte_out == 8'd0)

endmodule

bind delimited_frame_receiver_sum_check dfrsc_checker u_dfrsc_checker (.*);

`default_nettype wire
